@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each use clocks on clk and is
// switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define MWIC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define MWIC_ASSERT_IMP(label, ante, cons, msg) `MWIC_ASSERT(label, (ante) |-> (cons), msg)

`define MWIC_ASSERT_NXT(label, ante, cons, msg) `MWIC_ASSERT(label, (ante) |=> (cons), msg)

`endif

@@ hw/rtl/mwic_pkg.sv @@
package mwic_pkg;

  // Number of keys; must be a power of two so the tree is perfect.
  localparam int MAX_HEIGHT  = 1024;
  localparam int WEIGHT_BITS = 32;

  localparam int HEIGHT_W   = 11;
  localparam int BEAUTY_W   = 32;
  localparam int VAL_W      = 42;

  localparam int LEVELS     = $clog2(MAX_HEIGHT);
  localparam int NODE_W     = LEVELS + 1;
  localparam int TREE_DEPTH = 2 * MAX_HEIGHT;
  localparam int CNT_W      = $clog2(LEVELS + 2);
  localparam int EPOCH_W    = 4;
  localparam int ENTRY_W    = EPOCH_W + VAL_W;

  localparam logic [BEAUTY_W-1:0] WEIGHT_MASK = (WEIGHT_BITS >= BEAUTY_W) ?
      {BEAUTY_W{1'b1}} : BEAUTY_W'((64'd1 << WEIGHT_BITS) - 64'd1);

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [VAL_W-1:0]   val;
  } tree_entry_t;

  typedef struct packed {
    logic                start;
    logic                take;
    logic [HEIGHT_W-1:0] height;
    logic [BEAUTY_W-1:0] beauty;
    logic                last;
  } walk_cmd_t;

  typedef struct packed {
    logic             idle;
    logic             done;
    logic [VAL_W-1:0] chain_value;
    logic [VAL_W-1:0] best_so_far;
    logic             final_flag;
  } walk_sts_t;

endpackage

@@ hw/rtl/mwic_ifs.sv @@
interface mwic_in_if;
  import mwic_pkg::*;
  logic                valid;
  logic                ready;
  logic [HEIGHT_W-1:0] height;
  logic [BEAUTY_W-1:0] beauty;
  logic                last;

  modport source (output valid, output height, output beauty, output last, input ready);
  modport sink (input valid, input height, input beauty, input last, output ready);
endinterface

interface mwic_out_if;
  import mwic_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] chain_value;
  logic [VAL_W-1:0] best_so_far;
  logic             final_flag;

  modport source (output valid, output chain_value, output best_so_far, output final_flag,
                  input ready);
  modport sink (input valid, input chain_value, input best_so_far, input final_flag,
                output ready);
endinterface

@@ hw/rtl/mwic_ram.sv @@
module mwic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/mwic_walk.sv @@
`include "assert_macros.svh"

module mwic_walk (
  input  logic                clk,
  input  logic                rst_n,
  input  mwic_pkg::walk_cmd_t cmd,
  output mwic_pkg::walk_sts_t sts
);
  import mwic_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_QRD, S_ROOT, S_RDAT, S_ADD, S_UPD, S_DONE
  } state_t;

  state_t              state_r;
  logic [EPOCH_W-1:0]  epoch_r;
  logic [NODE_W-1:0]   clr_addr_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [NODE_W-1:0]   node_r;
  logic [LEVELS-1:0]   m_r;
  logic [LEVELS-1:0]   msh_r;
  logic                hi_r;
  logic                in_r;
  logic [BEAUTY_W-1:0] weight_r;
  logic                last_r;
  logic [VAL_W-1:0]    prefix_r;
  logic [VAL_W-1:0]    leaf_r;
  logic [VAL_W-1:0]    chain_r;
  logic [VAL_W-1:0]    cur_r;
  logic [VAL_W-1:0]    best_r;

  logic                ram_we;
  logic [NODE_W-1:0]   ram_waddr;
  tree_entry_t         ram_wdata;
  logic                ram_re;
  logic [NODE_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;
  tree_entry_t         rd_entry;

  logic [VAL_W-1:0]    rd_val;
  logic [VAL_W:0]      sum;
  logic [VAL_W-1:0]    chain_sat;
  logic [VAL_W-1:0]    add_max;
  logic [VAL_W-1:0]    up_max;
  logic [VAL_W-1:0]    prefix_max;
  logic [HEIGHT_W-1:0] hm1;
  logic                cmd_hi;
  logic                cmd_in;

  mwic_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TREE_DEPTH)
  ) u_tree (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_entry = ram_rdata;

  // Entries written in an older sequence read as zero.
  always_comb begin
    rd_val     = (rd_entry.epoch == epoch_r) ? rd_entry.val : '0;
    sum        = {1'b0, prefix_r} + {{(VAL_W + 1 - BEAUTY_W){1'b0}}, weight_r};
    chain_sat  = sum[VAL_W] ? '1 : sum[VAL_W-1:0];
    add_max    = (leaf_r > chain_sat) ? leaf_r : chain_sat;
    up_max     = (rd_val > cur_r) ? rd_val : cur_r;
    prefix_max = (rd_val > prefix_r) ? rd_val : prefix_r;
    hm1        = cmd.height - HEIGHT_W'(1);
    cmd_hi     = cmd.height > HEIGHT_W'(MAX_HEIGHT);
    cmd_in     = (cmd.height != '0) && !cmd_hi;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
      end
      S_QRD: begin
        // First the leaf, then the sibling of the path node at each level.
        ram_re    = cnt_r <= CNT_W'(LEVELS);
        ram_raddr = (cnt_r == '0) ? node_r : (node_r ^ NODE_W'(1));
      end
      S_ROOT: begin
        ram_re    = 1'b1;
        ram_raddr = NODE_W'(1);
      end
      S_UPD: begin
        ram_we          = 1'b1;
        ram_waddr       = node_r;
        ram_wdata.epoch = epoch_r;
        ram_wdata.val   = (cnt_r == '0) ? cur_r : up_max;
        ram_re          = 1'b1;
        ram_raddr       = node_r ^ NODE_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      epoch_r    <= '0;
      clr_addr_r <= '0;
      cnt_r      <= '0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + NODE_W'(1);
          if (clr_addr_r == '1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd.start) begin
            weight_r <= cmd.beauty & WEIGHT_MASK;
            last_r   <= cmd.last;
            m_r      <= hm1[LEVELS-1:0];
            msh_r    <= hm1[LEVELS-1:0];
            node_r   <= {1'b1, hm1[LEVELS-1:0]};
            hi_r     <= cmd_hi;
            in_r     <= cmd_in;
            prefix_r <= '0;
            leaf_r   <= '0;
            cnt_r    <= '0;
            state_r  <= cmd_in ? S_QRD : S_ROOT;
          end
        end
        S_QRD: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r != '0 && cnt_r <= CNT_W'(LEVELS)) begin
            node_r <= node_r >> 1;
          end
          // Data returned here belongs to the read issued in the previous cycle.
          if (cnt_r == CNT_W'(1)) begin
            leaf_r <= rd_val;
          end else if (cnt_r > CNT_W'(1)) begin
            // A right child on the path has its left sibling fully below the key.
            if (msh_r[0]) begin
              prefix_r <= prefix_max;
            end
            msh_r <= msh_r >> 1;
          end
          if (cnt_r == CNT_W'(LEVELS + 1)) begin
            state_r <= S_ADD;
          end
        end
        S_ROOT: begin
          state_r <= S_RDAT;
        end
        S_RDAT: begin
          best_r   <= rd_val;
          prefix_r <= hi_r ? rd_val : '0;
          state_r  <= S_ADD;
        end
        S_ADD: begin
          chain_r <= chain_sat;
          cur_r   <= add_max;
          node_r  <= {1'b1, m_r};
          cnt_r   <= '0;
          state_r <= in_r ? S_UPD : S_DONE;
        end
        S_UPD: begin
          cnt_r  <= cnt_r + CNT_W'(1);
          node_r <= node_r >> 1;
          if (cnt_r != '0) begin
            cur_r <= up_max;
          end
          if (cnt_r == CNT_W'(LEVELS)) begin
            best_r  <= up_max;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (cmd.take) begin
            clr_addr_r <= '0;
            if (last_r) begin
              epoch_r <= epoch_r + EPOCH_W'(1);
            end
            state_r <= (last_r && epoch_r == '1) ? S_CLEAR : S_IDLE;
          end
        end
        default: begin
          state_r <= S_CLEAR;
        end
      endcase
    end
  end

  assign sts.idle        = state_r == S_IDLE;
  assign sts.done        = state_r == S_DONE;
  assign sts.chain_value = chain_r;
  assign sts.best_so_far = best_r;
  assign sts.final_flag  = last_r;

  `MWIC_ASSERT_IMP(a_rw_apart, ram_we && ram_re, ram_waddr != ram_raddr, "read and write collide")
  `MWIC_ASSERT_IMP(a_root_ge_chain, sts.done && in_r, best_r >= chain_r, "root below chain value")
  `MWIC_ASSERT_NXT(a_done_holds, sts.done && !cmd.take, sts.done && $stable(chain_r), "result lost")
  `MWIC_ASSERT_NXT(a_epoch_step, sts.done && cmd.take && last_r, epoch_r == $past(epoch_r) + 1'b1, "epoch did not advance")

endmodule

@@ hw/rtl/max_weight_increasing_chain_unit.sv @@
// Maximum-weight strictly increasing chain over a stream of (height, beauty) items.
// in_ch carries height, beauty and last; an item transfers when valid and ready are
// both high. out_ch returns one result per item: chain_value, best_so_far and
// final_flag, which copies last. Items are handled one at a time.
// A height of 1 to MAX_HEIGHT walks the max tree held in one RAM: LEVELS+1 reads
// for the prefix query, one add, then LEVELS+1 read/write steps back up to the root.
// Other heights only read the root. In both cases the next input transfer waits until
// the result has been handed on and the walk is idle again.
// The result sits in an output register, so the next item is taken while it waits.
// If the receiver stalls with that register full, the finished item holds inside
// and input ready stays low until the register frees.
// After reset a clearing pass writes all 2*MAX_HEIGHT tree entries, one per cycle,
// with input ready low. After a last item the tree is logically cleared by moving to
// a new epoch; every sixteenth sequence end repeats the full clearing pass.
module max_weight_increasing_chain_unit (
  input logic        clk,
  input logic        rst_n,
  mwic_in_if.sink    in_ch,
  mwic_out_if.source out_ch
);
  import mwic_pkg::*;

  walk_cmd_t        cmd;
  walk_sts_t        sts;
  logic             out_valid_r;
  logic [VAL_W-1:0] chain_value_r;
  logic [VAL_W-1:0] best_so_far_r;
  logic             final_flag_r;

  assign in_ch.ready = sts.idle;

  always_comb begin
    cmd.start  = in_ch.valid && sts.idle;
    cmd.take   = !out_valid_r || out_ch.ready;
    cmd.height = in_ch.height;
    cmd.beauty = in_ch.beauty;
    cmd.last   = in_ch.last;
  end

  mwic_walk u_walk (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .sts   (sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sts.done && cmd.take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sts.done && cmd.take) begin
      chain_value_r <= sts.chain_value;
      best_so_far_r <= sts.best_so_far;
      final_flag_r  <= sts.final_flag;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.chain_value = chain_value_r;
  assign out_ch.best_so_far = best_so_far_r;
  assign out_ch.final_flag  = final_flag_r;

endmodule

@@ dv/tb_max_weight_increasing_chain_unit.sv @@
module tb_max_weight_increasing_chain_unit;
  import mwic_pkg::*;

  localparam logic [HEIGHT_W-1:0] HEIGHT_TOP = '1;

  typedef struct packed {
    logic [VAL_W-1:0] chain_value;
    logic [VAL_W-1:0] best_so_far;
    logic             final_flag;
  } chain_result_t;

  class chain_scoreboard;
    logic [VAL_W-1:0] key_best [1:MAX_HEIGHT];
    logic [VAL_W-1:0] seq_peak;
    chain_result_t    expected_results [$];
    int               errors;
    int               checked;
    int               off_range;
    int               seq_ends;

    function new();
      clear_store();
      errors    = 0;
      checked   = 0;
      off_range = 0;
      seq_ends  = 0;
    endfunction

    function void clear_store();
      foreach (key_best[k]) key_best[k] = '0;
      seq_peak = '0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Predicts the result of one transferred item and updates the key store.
    function void note_item(logic [HEIGHT_W-1:0] height, logic [BEAUTY_W-1:0] beauty,
                            logic last);
      logic [VAL_W-1:0] prefix;
      logic [VAL_W:0]   total;
      logic [VAL_W-1:0] chain;
      chain_result_t    res;
      int               top;
      int               k;
      prefix = '0;
      // Keys above the range see the whole store; key zero sees nothing.
      top = (height > MAX_HEIGHT) ? MAX_HEIGHT : int'(height) - 1;
      for (k = 1; k <= top; k++) begin
        if (key_best[k] > prefix) prefix = key_best[k];
      end
      total = {1'b0, prefix} + (VAL_W + 1)'(beauty & WEIGHT_MASK);
      chain = total[VAL_W] ? '1 : total[VAL_W-1:0];
      if (height >= 1 && height <= MAX_HEIGHT) begin
        if (chain > key_best[height]) key_best[height] = chain;
        if (chain > seq_peak) seq_peak = chain;
      end else begin
        off_range++;
      end
      res.chain_value = chain;
      res.best_so_far = seq_peak;
      res.final_flag  = last;
      expected_results.push_back(res);
      if (last) begin
        seq_ends++;
        clear_store();
      end
    endfunction

    function void check_result(chain_result_t got);
      chain_result_t want;
      if (expected_results.size() == 0) begin
        $error("result with no item waiting: chain_value %0d", got.chain_value);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (got.chain_value !== want.chain_value) begin
        $error("chain_value: expected %0d, got %0d", want.chain_value, got.chain_value);
        errors++;
      end
      if (got.best_so_far !== want.best_so_far) begin
        $error("best_so_far: expected %0d, got %0d", want.best_so_far, got.best_so_far);
        errors++;
      end
      if (got.final_flag !== want.final_flag) begin
        $error("final_flag: expected %0b, got %0b", want.final_flag, got.final_flag);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   bursts_on;
  int   items_sent;

  chain_scoreboard sb;

  mwic_in_if  in_ch ();
  mwic_out_if out_ch ();

  max_weight_increasing_chain_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      sb.note_item(in_ch.height, in_ch.beauty, in_ch.last);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result('{out_ch.chain_value, out_ch.best_so_far, out_ch.final_flag});
    end
  end

  // The receiver stalls in short random bursts while bursts are enabled.
  initial begin
    forever begin
      if (bursts_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_item(logic [HEIGHT_W-1:0] height, logic [BEAUTY_W-1:0] beauty,
                           logic last);
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.height <= height;
    in_ch.beauty <= beauty;
    in_ch.last   <= last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  function automatic logic [BEAUTY_W-1:0] draw_beauty();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 255);
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // One sequence ending in a last item. Shapes: spread keys, a narrow window
  // with many repeated keys, or a mostly climbing run that builds long chains.
  // A few items use key zero or keys above the range.
  task automatic run_sequence(int shape, int len);
    logic [HEIGHT_W-1:0] height;
    int                  base;
    int                  span;
    int                  climb;
    int                  i;
    base  = $urandom_range(1, MAX_HEIGHT);
    span  = $urandom_range(1, 16);
    climb = 0;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        height = $urandom_range(0, 1) ? '0 : HEIGHT_W'($urandom_range(MAX_HEIGHT + 1, HEIGHT_TOP));
      end else begin
        case (shape)
          0: height = HEIGHT_W'($urandom_range(1, MAX_HEIGHT));
          1: height = HEIGHT_W'((base + $urandom_range(0, span - 1) - 1) % MAX_HEIGHT + 1);
          default: begin
            climb += $urandom_range(0, 40);
            if (climb < 1 || climb > MAX_HEIGHT) climb = $urandom_range(1, 8);
            height = HEIGHT_W'(climb);
          end
        endcase
      end
      send_item(height, draw_beauty(), i == len - 1);
    end
  endtask

  function automatic int draw_length();
    return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
  endfunction

  initial begin
    sb           = new();
    items_sent   = 0;
    bursts_on    = 1'b1;
    in_ch.valid  <= 1'b0;
    in_ch.height <= '0;
    in_ch.beauty <= '0;
    in_ch.last   <= 1'b0;
    rst_n        <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Key extremes, repeated keys, key zero, keys above the range, weight extremes.
    send_item(11'd1,    32'h0000_0000, 1'b0);
    send_item(11'd1024, 32'hFFFF_FFFF, 1'b0);
    send_item(11'd2,    32'd5,         1'b0);
    send_item(11'd2,    32'd7,         1'b0);
    send_item(11'd3,    32'd1,         1'b0);
    send_item(11'd0,    32'd10,        1'b0);
    send_item(11'd1025, 32'd3,         1'b0);
    send_item(HEIGHT_TOP, 32'hFFFF_FFFF, 1'b0);
    send_item(11'd512,  32'hAAAA_AAAA, 1'b0);
    send_item(11'd1024, 32'h5555_5555, 1'b1);
    // Single-item sequences right after a clear.
    send_item(11'd1024, 32'hFFFF_FFFF, 1'b1);
    send_item(11'd1,    32'd42,        1'b1);
    send_item(11'd0,    32'hFFFF_FFFF, 1'b1);
    // A climbing chain of full weights builds large sums.
    send_item(11'd10,   32'hFFFF_FFFF, 1'b0);
    send_item(11'd20,   32'hFFFF_FFFF, 1'b0);
    send_item(11'd30,   32'hFFFF_FFFF, 1'b0);
    send_item(11'd40,   32'hFFFF_FFFF, 1'b1);

    while (items_sent < 700) begin
      bursts_on = ($urandom_range(0, 3) != 0);
      run_sequence($urandom_range(0, 2), draw_length());
    end
    bursts_on = 1'b0;
    while (items_sent < 800) run_sequence($urandom_range(0, 2), draw_length());
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d items in %0d sequences, %0d of them with keys outside 1..%0d.",
             items_sent, sb.seq_ends, sb.off_range, MAX_HEIGHT);
    $display("Checked %0d results, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/mwic_pkg.sv
hw/rtl/mwic_ifs.sv
hw/rtl/mwic_ram.sv
hw/rtl/mwic_walk.sv
hw/rtl/max_weight_increasing_chain_unit.sv
dv/tb_max_weight_increasing_chain_unit.sv
